// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, mode codes and keyword constants of the completeness scanner.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int MAX_NEST_DEFAULT = 255;

  // Scanner modes.
  localparam logic [3:0] M_NORMAL    = 4'd0;
  localparam logic [3:0] M_IDENT     = 4'd1;
  localparam logic [3:0] M_STRING    = 4'd2;
  localparam logic [3:0] M_ESCAPE    = 4'd3;
  localparam logic [3:0] M_SLASH     = 4'd4;
  localparam logic [3:0] M_COMMENT   = 4'd5;
  localparam logic [3:0] M_KW_GAP    = 4'd6;
  localparam logic [3:0] M_WHILE_GAP = 4'd7;
  localparam logic [3:0] M_HEAD      = 4'd8;

  // Head kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_COND  = 2'd1;
  localparam logic [1:0] KIND_WHILE = 2'd2;

  localparam logic [2:0] IDENT_MAX = 3'd5;

  // Keywords, packed right-aligned with the first character in the highest used byte.
  localparam logic [39:0] KW_WHILE = 40'h7768696c65;
  localparam logic [39:0] KW_IF    = 40'h0000006966;
  localparam logic [39:0] KW_RETRY = 40'h7265747279;
  localparam logic [39:0] KW_LOOP  = 40'h006c6f6f70;
  localparam logic [39:0] KW_ELSE  = 40'h00656c7365;
  localparam logic [39:0] KW_DO    = 40'h000000646f;

  // Scanner control state apart from the depth counters.
  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  resume;
    logic        brace_pending;
    logic        after_close;
    logic        early;
    logic [39:0] ident;
    logic [2:0]  ident_len;
    logic        too_long;
    logic [1:0]  kind;
    logic        overflow;
  } scs_ctl_t;

  localparam scs_ctl_t CTL_RESET = '{
    mode: M_NORMAL, resume: M_NORMAL, brace_pending: 1'b0, after_close: 1'b0,
    early: 1'b0, ident: 40'd0, ident_len: 3'd0, too_long: 1'b0,
    kind: KIND_NONE, overflow: 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic is_head(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_head(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic ident_is(input scs_ctl_t s, input logic [39:0] kw,
                                    input logic [2:0] len);
    return !s.too_long && s.ident_len == len && s.ident == kw;
  endfunction

endpackage

// ===== rtl/scs_step.sv =====
// ----------------------------------------------------------------------------
// scs_step
// One scanning pass over a byte in the current mode. Reports whether the byte
// must be scanned again in the mode it leaves behind.
// ----------------------------------------------------------------------------
module scs_step #(
  parameter int MAX_NEST = scs_pkg::MAX_NEST_DEFAULT,
  parameter int DW       = $clog2(MAX_NEST + 1)
) (
  input  scs_pkg::scs_ctl_t ctl_in,
  input  logic [DW-1:0]     paren_in,
  input  logic [DW-1:0]     brace_in,
  input  logic [DW-1:0]     head_in,
  input  logic [7:0]        c,
  output scs_pkg::scs_ctl_t ctl_out,
  output logic [DW-1:0]     paren_out,
  output logic [DW-1:0]     brace_out,
  output logic [DW-1:0]     head_out,
  output logic              again
);
  import scs_pkg::*;

  localparam logic [DW-1:0] LIMIT = DW'(MAX_NEST);

  logic          at_limit_p, at_limit_b, at_limit_h;
  logic [DW-1:0] brace_dec, head_dec;

  assign at_limit_p = paren_in >= LIMIT;
  assign at_limit_b = brace_in >= LIMIT;
  assign at_limit_h = head_in >= LIMIT;
  assign brace_dec  = brace_in - DW'(1);
  assign head_dec   = (head_in != '0) ? head_in - DW'(1) : head_in;

  // Mode dispatch for one pass.
  always_comb begin
    ctl_out   = ctl_in;
    paren_out = paren_in;
    brace_out = brace_in;
    head_out  = head_in;
    again     = 1'b0;
    case (ctl_in.mode)
      M_NORMAL: begin
        if (is_space(c)) begin
        end else if (c == 8'h2f) begin
          ctl_out.mode   = M_SLASH;
          ctl_out.resume = M_NORMAL;
        end else if (c == 8'h22) begin
          ctl_out.mode   = M_STRING;
          ctl_out.resume = M_NORMAL;
        end else if (c == 8'h28) begin
          if (at_limit_p) begin
            paren_out        = LIMIT;
            ctl_out.overflow = 1'b1;
          end else begin
            paren_out = paren_in + DW'(1);
          end
        end else if (c == 8'h29) begin
          if (paren_in == '0) ctl_out.early = 1'b1;
          else paren_out = paren_in - DW'(1);
        end else if (c == 8'h7b) begin
          if (at_limit_b) begin
            brace_out        = LIMIT;
            ctl_out.overflow = 1'b1;
          end else begin
            brace_out = brace_in + DW'(1);
          end
          ctl_out.brace_pending = 1'b0;
          ctl_out.after_close   = 1'b0;
        end else if (c == 8'h7d) begin
          if (brace_in == '0) begin
            ctl_out.early = 1'b1;
          end else begin
            brace_out = brace_dec;
            if (brace_dec == '0 && paren_in == '0) ctl_out.after_close = 1'b1;
          end
        end else if (is_head(c)) begin
          ctl_out.ident     = {32'd0, c};
          ctl_out.ident_len = 3'd1;
          ctl_out.too_long  = 1'b0;
          ctl_out.mode      = M_IDENT;
        end else if (c == 8'h3b) begin
          ctl_out.after_close = 1'b0;
        end else begin
          ctl_out.after_close   = 1'b0;
          ctl_out.brace_pending = 1'b0;
        end
      end
      M_IDENT: begin
        if (is_word(c)) begin
          if (ctl_in.ident_len < IDENT_MAX) begin
            ctl_out.ident     = {ctl_in.ident[31:0], c};
            ctl_out.ident_len = ctl_in.ident_len + 3'd1;
          end else begin
            ctl_out.too_long = 1'b1;
          end
        end else begin
          // Close the identifier and classify it.
          ctl_out.after_close = 1'b0;
          ctl_out.mode        = M_NORMAL;
          if (ctl_in.after_close && ident_is(ctl_in, KW_WHILE, 3'd5)) begin
            ctl_out.brace_pending = 1'b0;
            ctl_out.mode          = M_WHILE_GAP;
          end else if (ident_is(ctl_in, KW_IF, 3'd2) || ident_is(ctl_in, KW_RETRY, 3'd5) ||
                       ident_is(ctl_in, KW_LOOP, 3'd4)) begin
            ctl_out.mode = M_KW_GAP;
          end else if (ident_is(ctl_in, KW_ELSE, 3'd4) || ident_is(ctl_in, KW_DO, 3'd2)) begin
            ctl_out.brace_pending = 1'b1;
          end else begin
            ctl_out.brace_pending = 1'b0;
          end
          ctl_out.ident     = 40'd0;
          ctl_out.ident_len = 3'd0;
          ctl_out.too_long  = 1'b0;
          again             = 1'b1;
        end
      end
      M_STRING: begin
        if (c == 8'h5c) begin
          ctl_out.mode = M_ESCAPE;
        end else if (c == 8'h22) begin
          ctl_out.mode = ctl_in.resume;
          if (ctl_in.resume == M_NORMAL) begin
            ctl_out.brace_pending = 1'b0;
            ctl_out.after_close   = 1'b0;
          end
        end
      end
      M_ESCAPE: begin
        ctl_out.mode = M_STRING;
      end
      M_SLASH: begin
        if (c == 8'h2f) begin
          ctl_out.mode = M_COMMENT;
        end else if (ctl_in.resume == M_HEAD) begin
          ctl_out.mode = M_HEAD;
          again        = 1'b1;
        end else begin
          ctl_out.brace_pending = 1'b0;
          ctl_out.after_close   = 1'b0;
          ctl_out.mode          = M_NORMAL;
          ctl_out.resume        = M_NORMAL;
          again                 = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == 8'h0a) ctl_out.mode = ctl_in.resume;
      end
      M_KW_GAP, M_WHILE_GAP: begin
        if (is_space(c)) begin
        end else if (c == 8'h2f) begin
          ctl_out.resume = ctl_in.mode;
          ctl_out.mode   = M_SLASH;
        end else if (c == 8'h28) begin
          ctl_out.kind = (ctl_in.mode == M_KW_GAP) ? KIND_COND : KIND_WHILE;
          head_out     = DW'(1);
          ctl_out.mode = M_HEAD;
        end else begin
          if (ctl_in.mode == M_KW_GAP) ctl_out.brace_pending = 1'b1;
          ctl_out.mode = M_NORMAL;
          again        = 1'b1;
        end
      end
      M_HEAD: begin
        if (c == 8'h22) begin
          ctl_out.mode   = M_STRING;
          ctl_out.resume = M_HEAD;
        end else if (c == 8'h2f) begin
          ctl_out.mode   = M_SLASH;
          ctl_out.resume = M_HEAD;
        end else if (c == 8'h28) begin
          if (at_limit_h) begin
            head_out         = LIMIT;
            ctl_out.overflow = 1'b1;
          end else begin
            head_out = head_in + DW'(1);
          end
        end else if (c == 8'h29) begin
          head_out = head_dec;
          if (head_dec == '0) begin
            ctl_out.brace_pending = (ctl_in.kind == KIND_COND);
            ctl_out.kind          = KIND_NONE;
            ctl_out.mode          = M_NORMAL;
          end
        end
      end
      default: begin
        ctl_out.mode = M_NORMAL;
        again        = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/script_completeness_scanner_unit.sv =====
// Script completeness scanner.
// Input channel: text_byte and last_byte, qualified by text_valid, held off
// by text_stall. Output channel: complete and nest_overflow, qualified by
// result_valid, held off by result_stall. One result leaves for each
// transaction whose last_byte is set; other bytes give no result.
// A byte is taken into an input register, scanned in the next cycle by
// up to three chained passes of the mode logic, and the result, if any, is
// written to the output register as the final byte leaves the input
// register. One byte is accepted every cycle unless a final byte waits.
// The scanner state returns to its reset values after each final byte, so
// texts follow each other without a gap.
// When the receiver stalls, a held result blocks only a further final
// byte; ordinary bytes keep streaming. Reset (rst, synchronous) empties
// both registers and clears the scanner state.
// ----------------------------------------------------------------------------
// script_completeness_scanner_unit
// Top level: input register, scan passes, state and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module script_completeness_scanner_unit #(
  parameter int MAX_NEST = scs_pkg::MAX_NEST_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       complete,
  output logic       nest_overflow
);
  import scs_pkg::*;

  localparam int DW = $clog2(MAX_NEST + 1);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Scanner state.
  scs_ctl_t      ctl;
  logic [DW-1:0] paren, brace, head;

  logic advance, out_free;

  scs_ctl_t      ctl1, ctl2, ctl3, ctl_fin, post, fin;
  logic [DW-1:0] p1, p2, p3, pf, b1, b2, b3, bf, h1, h2, h3, hf;
  logic [DW-1:0] post_p, post_b, post_h;
  logic          again1, again2, again3, again_f;
  logic          open_text, pending, ok;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && (!in_last || out_free);
  assign text_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!text_stall) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall && text_valid) begin
      in_byte <= text_byte;
      in_last <= last_byte;
    end
  end

  // Up to three passes: identifier end, keyword gap, then normal scanning.
  scs_step #(.MAX_NEST(MAX_NEST), .DW(DW)) u_pass1 (
    .ctl_in(ctl), .paren_in(paren), .brace_in(brace), .head_in(head), .c(in_byte),
    .ctl_out(ctl1), .paren_out(p1), .brace_out(b1), .head_out(h1), .again(again1));
  scs_step #(.MAX_NEST(MAX_NEST), .DW(DW)) u_pass2 (
    .ctl_in(ctl1), .paren_in(p1), .brace_in(b1), .head_in(h1), .c(in_byte),
    .ctl_out(ctl2), .paren_out(p2), .brace_out(b2), .head_out(h2), .again(again2));
  scs_step #(.MAX_NEST(MAX_NEST), .DW(DW)) u_pass3 (
    .ctl_in(ctl2), .paren_in(p2), .brace_in(b2), .head_in(h2), .c(in_byte),
    .ctl_out(ctl3), .paren_out(p3), .brace_out(b3), .head_out(h3), .again(again3));

  // Pick the state after the last pass that ran; a latched answer freezes it.
  always_comb begin
    if (ctl.early) begin
      post = ctl; post_p = paren; post_b = brace; post_h = head;
    end else if (!again1) begin
      post = ctl1; post_p = p1; post_b = b1; post_h = h1;
    end else if (!again2) begin
      post = ctl2; post_p = p2; post_b = b2; post_h = h2;
    end else begin
      post = ctl3; post_p = p3; post_b = b3; post_h = h3;
    end
  end

  // A space in identifier mode closes the word at the end of the text.
  scs_step #(.MAX_NEST(MAX_NEST), .DW(DW)) u_close (
    .ctl_in(post), .paren_in(post_p), .brace_in(post_b), .head_in(post_h), .c(8'h20),
    .ctl_out(ctl_fin), .paren_out(pf), .brace_out(bf), .head_out(hf), .again(again_f));

  // End-of-text verdict.
  always_comb begin
    fin       = (post.mode == M_IDENT) ? ctl_fin : post;
    open_text = fin.mode == M_STRING || fin.mode == M_ESCAPE || fin.mode == M_HEAD ||
                ((fin.mode == M_SLASH || fin.mode == M_COMMENT) && fin.resume == M_HEAD);
    pending   = fin.brace_pending;
    if (fin.mode == M_KW_GAP || (fin.mode == M_COMMENT && fin.resume == M_KW_GAP)) begin
      pending = 1'b1;
    end
    if (fin.mode == M_SLASH && fin.resume != M_HEAD) pending = 1'b0;
    ok = post.early || (!open_text && post_p == '0 && post_b == '0 && !pending &&
                        (again_f || !again_f));
  end

  // State update; a final byte returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl   <= CTL_RESET;
      paren <= '0;
      brace <= '0;
      head  <= '0;
    end else if (advance) begin
      if (in_last) begin
        ctl   <= CTL_RESET;
        paren <= '0;
        brace <= '0;
        head  <= '0;
      end else begin
        ctl   <= post;
        paren <= post_p;
        brace <= post_b;
        head  <= post_h;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && in_last) begin
      complete      <= ok;
      nest_overflow <= post.overflow;
    end
  end

  `ASSERT_CLK(a_stall_needs_item, !in_valid |-> !text_stall, "stall without held transaction")
  `ASSERT_CLK(a_reset_after_last, advance && in_last |=> (paren == '0 && brace == '0 &&
    head == '0 && !ctl.early && ctl.mode == M_NORMAL), "state not cleared after final byte")
  `ASSERT_CLK(a_depth_limit, paren <= DW'(MAX_NEST) && brace <= DW'(MAX_NEST) &&
    head <= DW'(MAX_NEST), "depth counter above limit")
  `ASSERT_CLK(a_result_from_last, $rose(result_valid) |-> $past(advance && in_last),
    "result without final byte")

endmodule

// ===== sim/script_completeness_scanner_unit_test.sv =====
// ----------------------------------------------------------------------------
// Completeness scanner testbench
// Streams script texts through the scanner and checks each result against a
// behavioral prediction of the scan rules. Texts are mostly well-formed
// keyword constructs with random damage, plus noise and deep nesting.
// ----------------------------------------------------------------------------
module script_completeness_scanner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scs_pkg::*;

  localparam int NEST_LIMIT = 255;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } byte_txn_t;

  typedef struct {
    logic done;
    logic ovf;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       complete;
  logic       nest_overflow;

  byte_txn_t  pending_bytes[$];
  verdict_t   expected_verdicts[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         texts_sent = 0;
  int         items_queued = 0;
  int         verdicts_seen = 0;
  bit         quiet_phase = 1'b0;
  bit         feeding_done = 1'b0;
  int         send_gap = 0;
  int         recv_gap = 0;

  // Stall as seen at the last rising edge, so the driver knows acceptance.
  logic text_stall_s = 1'b0;
  logic took_byte = 1'b0;

  // Scanner state as predicted by the testbench.
  logic [3:0]  mode_q, resume_q;
  int          paren_q, brace_q, head_q;
  logic        pend_q, after_q, early_q, too_long_q, ovf_q;
  logic [39:0] word_q;
  int          word_len_q;
  logic [1:0]  kind_q;

  script_completeness_scanner_unit dut (.*);

  always #2 clk = ~clk;

  function automatic bit blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic int nest_up(int d);
    if (d >= NEST_LIMIT) begin
      ovf_q = 1'b1;
      return NEST_LIMIT;
    end
    return d + 1;
  endfunction

  function automatic bit word_eq(logic [39:0] kw, int n);
    return !too_long_q && word_len_q == n && word_q == kw;
  endfunction

  function automatic void clear_scan();
    mode_q = M_NORMAL; resume_q = M_NORMAL;
    paren_q = 0; brace_q = 0; head_q = 0;
    pend_q = 0; after_q = 0; early_q = 0; too_long_q = 0; ovf_q = 0;
    word_q = '0; word_len_q = 0; kind_q = KIND_NONE;
  endfunction

  function automatic void word_push(logic [7:0] c);
    if (word_len_q < 5) begin
      word_q = {word_q[31:0], c};
      word_len_q++;
    end else begin
      too_long_q = 1'b1;
    end
  endfunction

  function automatic void close_word();
    bit was_after;
    was_after = after_q;
    after_q = 0;
    mode_q = M_NORMAL;
    if (was_after && word_eq(KW_WHILE, 5)) begin
      pend_q = 0;
      mode_q = M_WHILE_GAP;
    end else if (word_eq(KW_IF, 2) || word_eq(KW_RETRY, 5) || word_eq(KW_LOOP, 4)) begin
      mode_q = M_KW_GAP;
    end else if (word_eq(KW_ELSE, 4) || word_eq(KW_DO, 2)) begin
      pend_q = 1;
    end else begin
      pend_q = 0;
    end
    word_q = '0; word_len_q = 0; too_long_q = 0;
  endfunction

  // One pass of the mode logic; returns 1 when the byte must be rescanned.
  function automatic bit scan_pass(logic [7:0] c);
    case (mode_q)
      M_NORMAL: begin
        if (blank(c)) begin
        end else if (c == "/") begin
          mode_q = M_SLASH; resume_q = M_NORMAL;
        end else if (c == "\"") begin
          mode_q = M_STRING; resume_q = M_NORMAL;
        end else if (c == "(") begin
          paren_q = nest_up(paren_q);
        end else if (c == ")") begin
          if (paren_q == 0) early_q = 1; else paren_q--;
        end else if (c == "{") begin
          brace_q = nest_up(brace_q); pend_q = 0; after_q = 0;
        end else if (c == "}") begin
          if (brace_q == 0) early_q = 1;
          else begin
            brace_q--;
            if (brace_q == 0 && paren_q == 0) after_q = 1;
          end
        end else if (letter(c)) begin
          word_q = '0; word_len_q = 0; too_long_q = 0;
          word_push(c);
          mode_q = M_IDENT;
        end else if (c == ";") begin
          after_q = 0;
        end else begin
          after_q = 0; pend_q = 0;
        end
        return 0;
      end
      M_IDENT: begin
        if (letter(c) || (c >= "0" && c <= "9")) begin
          word_push(c);
          return 0;
        end
        close_word();
        return 1;
      end
      M_STRING: begin
        if (c == "\\") mode_q = M_ESCAPE;
        else if (c == "\"") begin
          mode_q = resume_q;
          if (resume_q == M_NORMAL) begin
            pend_q = 0; after_q = 0;
          end
        end
        return 0;
      end
      M_ESCAPE: begin
        mode_q = M_STRING;
        return 0;
      end
      M_SLASH: begin
        if (c == "/") begin
          mode_q = M_COMMENT;
          return 0;
        end
        if (resume_q == M_HEAD) begin
          mode_q = M_HEAD;
          return 1;
        end
        pend_q = 0; after_q = 0; mode_q = M_NORMAL; resume_q = M_NORMAL;
        return 1;
      end
      M_COMMENT: begin
        if (c == 8'h0a) mode_q = resume_q;
        return 0;
      end
      M_KW_GAP, M_WHILE_GAP: begin
        if (blank(c)) return 0;
        if (c == "/") begin
          resume_q = mode_q; mode_q = M_SLASH;
          return 0;
        end
        if (c == "(") begin
          kind_q = (mode_q == M_KW_GAP) ? KIND_COND : KIND_WHILE;
          head_q = 1; mode_q = M_HEAD;
          return 0;
        end
        if (mode_q == M_KW_GAP) pend_q = 1;
        mode_q = M_NORMAL;
        return 1;
      end
      M_HEAD: begin
        if (c == "\"") begin
          mode_q = M_STRING; resume_q = M_HEAD;
        end else if (c == "/") begin
          mode_q = M_SLASH; resume_q = M_HEAD;
        end else if (c == "(") begin
          head_q = nest_up(head_q);
        end else if (c == ")") begin
          if (head_q > 0) head_q--;
          if (head_q == 0) begin
            pend_q = (kind_q == KIND_COND); kind_q = KIND_NONE; mode_q = M_NORMAL;
          end
        end
        return 0;
      end
      default: begin
        mode_q = M_NORMAL;
        return 1;
      end
    endcase
  endfunction

  // Verdict on the final byte of a text.
  function automatic logic text_is_complete();
    bit open;
    open = 0;
    if (early_q) return 1;
    if (mode_q == M_IDENT) close_word();
    if (mode_q == M_STRING || mode_q == M_ESCAPE || mode_q == M_HEAD) open = 1;
    if ((mode_q == M_SLASH || mode_q == M_COMMENT) && resume_q == M_HEAD) open = 1;
    if (mode_q == M_KW_GAP || (mode_q == M_COMMENT && resume_q == M_KW_GAP)) pend_q = 1;
    if (mode_q == M_SLASH && resume_q != M_HEAD) pend_q = 0;
    return !open && paren_q == 0 && brace_q == 0 && !pend_q;
  endfunction

  function automatic void predict_byte(byte_txn_t t);
    verdict_t v;
    for (int i = 0; i < 4 && !early_q; i++)
      if (!scan_pass(t.ch)) break;
    if (t.fin) begin
      v.done = text_is_complete();
      v.ovf = ovf_q;
      expected_verdicts = {expected_verdicts, v};
      clear_scan();
    end
  endfunction

  // Queue helpers for building texts.
  task automatic put_str(string s, bit fin_at_end);
    byte_txn_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.ch = s[i];
      t.fin = fin_at_end && (i == s.len() - 1);
      pending_bytes = {pending_bytes, t};
      items_queued++;
    end
    if (fin_at_end) texts_sent++;
  endtask

  task automatic put_byte(logic [7:0] c, bit fin);
    byte_txn_t t;
    t.ch = c; t.fin = fin;
    pending_bytes = {pending_bytes, t};
    items_queued++;
    if (fin) texts_sent++;
  endtask

  function automatic string pick_fragment();
    case ($urandom_range(0, 23))
      0: return "if (a) { x; }";
      1: return "if(b(c)){y}else{z}";
      2: return "retry (n) {\n}";
      3: return "loop (1) { f(); }";
      4: return "do { q } while (k);";
      5: return "else { }";
      6: return "x = \"s\\\"t\";";
      7: return "// note\n";
      8: return "if /* */ (a) {}";
      9: return "if // c\n (a) {}";
      10: return "while (x) {";
      11: return "f(a, (b));";
      12: return "{ }";
      13: return "if (\"(\") {}";
      14: return "loopy whiles retrying";
      15: return "do";
      16: return "if (a /2) {}";
      17: return "{ } while";
      18: return "\"open";
      19: return "if x";
      20: return "abc_12 ;";
      21: return "(";
      22: return ")";
      default: return "}";
    endcase
  endfunction

  // Stimulus: directed texts, random texts, then a plain streaming run.
  initial begin
    string s;
    int n;
    for (int i = 0; i < 7; i++) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    put_str("x", 1);
    put_str("if (a) { b; }", 1);
    put_str("if (a)", 1);
    put_str("else {", 1);
    put_str("do {} while (x", 1);
    put_str("retry(\"\\\"\"){}", 1);
    put_str("loop ( ( ) ) { // c\n}", 1);
    put_str(")) {", 1);
    put_str("}", 1);
    put_str("a /", 1);
    put_str("if (a /", 1);
    put_str("\"abc\\", 1);
    put_str("abcdefif (x)", 1);
    put_str("if // c", 1);
    put_byte(8'hff, 0); put_byte(8'h80, 0); put_byte(8'h00, 1);
    for (int i = 0; i < 257; i++) put_byte("(", 0);
    put_byte(")", 1);
    put_str("while(((", 1);
    for (int i = 0; i < 32; i++) put_byte(8'(i * 8 + 3), 0);
    put_byte(8'h7f, 1);

    while (items_queued < 450) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        s = pick_fragment();
        if ($urandom_range(0, 4) == 0 && s.len() > 1)
          s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
        put_str(s, 0);
      end
      if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(0, 255)), 0);
      put_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h20, 1);
    end
    // Plain streaming without idling at the end.
    for (int i = 0; i < 10; i++) put_str("if (a) {b}", 1);
    wait (pending_bytes.size() <= 100);
    quiet_phase = 1'b1;
    wait (pending_bytes.size() == 0 && !text_valid);
    feeding_done = 1'b1;
  end

  // Driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (!(text_valid && text_stall_s)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          text_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          if (!quiet_phase && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(1, 10);
            text_valid <= 1'b0;
          end else begin
            byte_txn_t t;
            t = pending_bytes.pop_front();
            text_byte <= t.ch;
            last_byte <= t.fin;
            text_valid <= 1'b1;
          end
        end else begin
          text_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 12) == 0) begin
        recv_gap <= $urandom_range(1, 10);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    verdict_t v;
    text_stall_s <= text_stall;
    if (rst) begin
      clear_scan();
    end else begin
      took_byte = 1'b0;
      if (text_valid && !text_stall) begin
        byte_txn_t t;
        t.ch = text_byte; t.fin = last_byte;
        predict_byte(t);
        took_byte = 1'b1;
      end
      if (result_valid && !result_stall) begin
        took_byte = 1'b1;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result complete=%0b nest_overflow=%0b",
                   $realtime, complete, nest_overflow);
        end else begin
          v = expected_verdicts.pop_front();
          if (complete !== v.done) begin
            errors++;
            $display("%0t: complete expected %0b actual %0b", $realtime, v.done, complete);
          end
          if (nest_overflow !== v.ovf) begin
            errors++;
            $display("%0t: nest_overflow expected %0b actual %0b",
                     $realtime, v.ovf, nest_overflow);
          end
        end
      end
      idle_cycles <= took_byte ? 0 : idle_cycles + 1;
    end
  end

  // End of run and watchdog.
  initial begin
    wait (feeding_done && expected_verdicts.size() == 0);
    for (int i = 0; i < 10; i++) @(posedge clk);
    $display("Checked %0d texts, %0d results, including saturated nesting and byte noise.",
             texts_sent, verdicts_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Watchdog expired after %0d idle cycles.", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end
endmodule
